/* rtl/b64sd_pkg.sv */
`timescale 1ns / 1ps

package b64sd_pkg;

  // Queue between the classifier and the execution side
  localparam int unsigned QDepth  = 4;
  localparam int unsigned QPtrW   = $clog2(QDepth);
  localparam int unsigned QCountW = $clog2(QDepth + 1);

  // Final status codes
  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StBadChar  = 2'd1;
  localparam logic [1:0] StAfterPad = 2'd2;
  localparam logic [1:0] StTrunc    = 2'd3;

  // Number of leftover bits that make a truncated quantum
  localparam logic [2:0] TruncCount = 3'd6;

  // Item classes after the front classifier
  typedef enum logic [2:0] {
    ClsSextet = 3'd0,
    ClsBad    = 3'd1,
    ClsPad    = 3'd2,
    ClsEnd    = 3'd3,
    ClsSkip   = 3'd4
  } cls_e;

  typedef struct packed {
    cls_e       cls;
    logic [5:0] sextet;
  } item_t;

  // Classify one raw character
  function automatic item_t classify(input logic kind, input logic [7:0] ch);
    item_t it;
    it.cls    = ClsBad;
    it.sextet = 6'd0;
    if (kind) begin
      it.cls = ClsEnd;
    end else if (ch >= "A" && ch <= "Z") begin
      it.cls    = ClsSextet;
      it.sextet = 6'(ch - 8'(65));
    end else if (ch >= "a" && ch <= "z") begin
      it.cls    = ClsSextet;
      it.sextet = 6'(ch - 8'(97) + 8'd26);
    end else if (ch >= "0" && ch <= "9") begin
      it.cls    = ClsSextet;
      it.sextet = 6'(ch - 8'(48) + 8'd52);
    end else if (ch == "+") begin
      it.cls    = ClsSextet;
      it.sextet = 6'd62;
    end else if (ch == "/") begin
      it.cls    = ClsSextet;
      it.sextet = 6'd63;
    end else if (ch == "=") begin
      it.cls = ClsPad;
    end else if (ch == 8'h20 || ch == 8'h09 || ch == 8'h0d || ch == 8'h0a) begin
      it.cls = ClsSkip;
    end
    return it;
  endfunction

endpackage

/* rtl/b64sd_front.sv */
`timescale 1ns / 1ps

module b64sd_front (
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               in_kind_i,
  input  logic [7:0]         in_character_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output b64sd_pkg::item_t   q_item_o
);

  b64sd_pkg::item_t item;

  // Classify; whitespace is dropped here and never enters the queue
  always_comb begin
    item       = b64sd_pkg::classify(in_kind_i, in_character_i);
    in_stall_o = q_full_i;
    q_push_o   = in_valid_i && !q_full_i && (item.cls != b64sd_pkg::ClsSkip);
    q_item_o   = item;
  end

endmodule

/* rtl/b64sd_queue.sv */
`timescale 1ns / 1ps

module b64sd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  b64sd_pkg::item_t    push_item_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output b64sd_pkg::item_t    head_o
);

  b64sd_pkg::item_t                    mem_q [b64sd_pkg::QDepth];
  logic [b64sd_pkg::QPtrW-1:0]         wr_ptr_q, wr_ptr_d;
  logic [b64sd_pkg::QPtrW-1:0]         rd_ptr_q, rd_ptr_d;
  logic [b64sd_pkg::QCountW-1:0]       count_q, count_d;

  assign full_o  = (count_q == b64sd_pkg::QCountW'(b64sd_pkg::QDepth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

/* rtl/b64sd_back.sv */
`timescale 1ns / 1ps

module b64sd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  b64sd_pkg::item_t   q_head_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         out_data_byte_o,
  output logic [1:0]         out_status_o,
  output logic               out_is_last_o
);

  logic [5:0]  left_q, left_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        pad_q, pad_d;
  logic [1:0]  err_q, err_d;
  logic        ovalid_q, ovalid_d;
  logic [7:0]  obyte_q, obyte_d;
  logic [1:0]  ostat_q, ostat_d;
  logic        olast_q, olast_d;

  logic        adv;
  logic        emit;
  logic [11:0] acc;
  logic [2:0]  rest;

  // Output register frees when empty or taken
  assign adv     = !ovalid_q || !out_stall_i;
  assign q_pop_o = q_valid_i && adv;
  assign acc     = {left_q, q_head_i.sextet};
  assign rest    = cnt_q - 3'd2;

  // Execute one queued transaction
  always_comb begin
    left_d  = left_q;
    cnt_d   = cnt_q;
    pad_d   = pad_q;
    err_d   = err_q;
    emit    = 1'b0;
    obyte_d = obyte_q;
    ostat_d = ostat_q;
    olast_d = olast_q;
    if (q_pop_o) begin
      case (q_head_i.cls) inside
        b64sd_pkg::ClsEnd: begin
          emit    = 1'b1;
          obyte_d = 8'd0;
          olast_d = 1'b1;
          if (err_q != b64sd_pkg::StOk) begin
            ostat_d = err_q;
          end else if (cnt_q == b64sd_pkg::TruncCount) begin
            ostat_d = b64sd_pkg::StTrunc;
          end else begin
            ostat_d = b64sd_pkg::StOk;
          end
          left_d = '0;
          cnt_d  = '0;
          pad_d  = 1'b0;
          err_d  = b64sd_pkg::StOk;
        end
        b64sd_pkg::ClsPad: begin
          pad_d = 1'b1;
        end
        b64sd_pkg::ClsSextet, b64sd_pkg::ClsBad: begin
          if (err_q != b64sd_pkg::StOk) begin
            // latched error: ignore
          end else if (pad_q) begin
            err_d = b64sd_pkg::StAfterPad;
          end else if (q_head_i.cls == b64sd_pkg::ClsBad) begin
            err_d = b64sd_pkg::StBadChar;
          end else if (cnt_q == 3'd0) begin
            left_d = q_head_i.sextet;
            cnt_d  = 3'd6;
          end else begin
            // eight or more bits now present
            emit    = 1'b1;
            obyte_d = 8'(acc >> rest);
            ostat_d = b64sd_pkg::StOk;
            olast_d = 1'b0;
            cnt_d   = rest;
            left_d  = q_head_i.sextet & ((6'd1 << rest) - 6'd1);
          end
        end
        default: begin
        end
      endcase
    end
    ovalid_d = adv ? emit : ovalid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      cnt_q    <= '0;
      pad_q    <= 1'b0;
      err_q    <= b64sd_pkg::StOk;
      ovalid_q <= 1'b0;
    end else begin
      left_q   <= left_d;
      cnt_q    <= cnt_d;
      pad_q    <= pad_d;
      err_q    <= err_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      obyte_q <= obyte_d;
      ostat_q <= ostat_d;
      olast_q <= olast_d;
    end
  end

  assign out_valid_o     = ovalid_q;
  assign out_data_byte_o = obyte_q;
  assign out_status_o    = ostat_q;
  assign out_is_last_o   = olast_q;

endmodule

/* rtl/base64_stream_decoder.sv */
// Streaming base64 decoder.
// Input channel (in_valid_i / in_stall_o): one transaction per character,
// or an end-of-string marker when in_kind_i is 1. Space, tab, CR and LF
// are dropped at the input; '=' marks padding; other characters outside
// the standard alphabet latch an error.
// Output channel (out_valid_o / out_stall_i): one transaction per decoded
// byte, plus one closing transaction per string with out_is_last_o set,
// out_data_byte_o zero and the final status (ok, invalid character, data
// after padding, truncated quantum).
// Throughput: one transaction per cycle on both sides while the queue is
// not full and the receiver does not stall. A classifier feeds a
// four-entry queue; the execution side pops one entry per cycle into a
// single output register while that register is empty or being taken.
// When the receiver stalls, the output register holds and the queue fills;
// in_stall_o rises only once the queue is full.
// Reset empties the queue, clears output valid and all decode state.
`timescale 1ns / 1ps

module base64_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        in_kind_i,
  input  logic [7:0]  in_character_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_data_byte_o,
  output logic [1:0]  out_status_o,
  output logic        out_is_last_o
);

  logic              q_full;
  logic              q_push;
  logic              q_pop;
  logic              q_valid;
  b64sd_pkg::item_t  q_push_item;
  b64sd_pkg::item_t  q_head;

  b64sd_front u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_kind_i      (in_kind_i),
    .in_character_i (in_character_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_item_o       (q_push_item)
  );

  b64sd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (q_push_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  b64sd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_head_i        (q_head),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_data_byte_o (out_data_byte_o),
    .out_status_o    (out_status_o),
    .out_is_last_o   (out_is_last_o)
  );

endmodule

/* rtl/b64sd_checker.sv */
`timescale 1ns / 1ps

module b64sd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_data_byte_o,
  input logic [1:0] out_status_o,
  input logic       out_is_last_o
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_byte_o)
      && $stable(out_status_o) && $stable(out_is_last_o))
    else $error("output transaction changed while stalled");

  // Closing transaction carries a zero byte
  a_last_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_is_last_o |-> out_data_byte_o == 8'd0)
    else $error("closing transaction with nonzero byte");

  // Data bytes always report ok
  a_data_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_is_last_o |-> out_status_o == b64sd_pkg::StOk)
    else $error("data byte with nonzero status");

  // Nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

endmodule

bind base64_stream_decoder b64sd_checker u_b64sd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .out_data_byte_o (out_data_byte_o),
  .out_status_o    (out_status_o),
  .out_is_last_o   (out_is_last_o)
);

/* tb/base64_decode_checker.sv */
`timescale 1ns / 1ps

module base64_decode_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic              in_kind_i,
  input  logic [7:0]        in_character_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [7:0]        out_data_byte_i,
  input  logic [1:0]        out_status_i,
  input  logic              out_is_last_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o
);

  typedef struct packed {
    logic [7:0] data_byte;
    logic [1:0] status;
    logic       is_last;
  } dec_result_t;

  // Characters with a meaning of their own
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChPad   = "=";

  // Marker for a character outside the alphabet
  localparam logic [6:0] NoSextet = 7'd64;

  // Predicted decoder state
  logic [5:0]  carry_bits;
  logic [2:0]  carry_count;
  logic        pad_seen;
  logic [1:0]  latched_err;

  dec_result_t expected_results[$];

  function automatic logic [6:0] sextet_of_char(input logic [7:0] ch);
    if (ch >= "A" && ch <= "Z") return 7'(ch - 8'("A"));
    if (ch >= "a" && ch <= "z") return 7'(ch - 8'("a") + 8'd26);
    if (ch >= "0" && ch <= "9") return 7'(ch - 8'("0") + 8'd52);
    if (ch == "+") return 7'd62;
    if (ch == "/") return 7'd63;
    return NoSextet;
  endfunction

  task automatic clear_state();
    carry_bits  = '0;
    carry_count = '0;
    pad_seen    = 1'b0;
    latched_err = b64sd_pkg::StOk;
  endtask

  // Advance the predicted state by one accepted transaction
  task automatic decode_item(input logic kind, input logic [7:0] ch);
    logic [6:0]  sx;
    logic [11:0] acc;
    int unsigned total;
    int unsigned rest;
    dec_result_t res;
    if (kind) begin
      res.data_byte = 8'h00;
      res.status    = latched_err;
      res.is_last   = 1'b1;
      if (latched_err == b64sd_pkg::StOk && carry_count == b64sd_pkg::TruncCount)
        res.status = b64sd_pkg::StTrunc;
      expected_results.insert(expected_results.size(), res);
      clear_state();
    end else if (ch == ChSpace || ch == ChTab || ch == ChCr || ch == ChLf) begin
      // whitespace: dropped
    end else if (ch == ChPad) begin
      pad_seen = 1'b1;
    end else if (latched_err != b64sd_pkg::StOk) begin
      // error latched: nothing more is decoded
    end else if (pad_seen) begin
      latched_err = b64sd_pkg::StAfterPad;
    end else begin
      sx = sextet_of_char(ch);
      if (sx == NoSextet) begin
        latched_err = b64sd_pkg::StBadChar;
      end else begin
        acc   = {carry_bits, sx[5:0]};
        total = carry_count + 6;
        if (total >= 8) begin
          rest          = total - 8;
          res.data_byte = 8'(acc >> rest);
          res.status    = b64sd_pkg::StOk;
          res.is_last   = 1'b0;
          expected_results.insert(expected_results.size(), res);
          carry_count   = 3'(rest);
          carry_bits    = 6'(acc & ((12'd1 << rest) - 12'd1));
        end else begin
          carry_count = 3'(total);
          carry_bits  = acc[5:0];
        end
      end
    end
  endtask

  // Compare one output transaction with the oldest prediction
  task automatic check_result();
    dec_result_t want;
    if (expected_results.size() == 0) begin
      $error("unexpected result: data_byte 8'h%02h status %0d is_last %0b",
             out_data_byte_i, out_status_i, out_is_last_i);
      fail_count_o++;
    end else begin
      want = expected_results.pop_front();
      if (out_data_byte_i !== want.data_byte) begin
        $error("data_byte: expected 8'h%02h, got 8'h%02h", want.data_byte, out_data_byte_i);
        fail_count_o++;
      end
      if (out_status_i !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, out_status_i);
        fail_count_o++;
      end
      if (out_is_last_i !== want.is_last) begin
        $error("is_last: expected %0b, got %0b", want.is_last, out_is_last_i);
        fail_count_o++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
      expected_results.delete();
      pending_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) decode_item(in_kind_i, in_character_i);
      if (out_valid_i && !out_stall_i) check_result();
      pending_o = expected_results.size();
    end
  end

endmodule

/* tb/base64_stream_decoder_tb.sv */
`timescale 1ns / 1ps

module base64_stream_decoder_tb;

  // Kinds of damage done to a random string
  localparam int FlawNone     = 0;
  localparam int FlawNoise    = 1;
  localparam int FlawAfterPad = 2;
  localparam int FlawTruncate = 3;
  localparam int FlawGarbage  = 4;

  localparam logic [7:0] Blanks [4] = '{8'h20, 8'h09, 8'h0d, 8'h0a};

  localparam int unsigned ItemTarget = 1200;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_kind;
  logic [7:0]  in_character;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_data_byte;
  logic [1:0]  out_status;
  logic        out_is_last;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned sent_items;
  bit          steady_run;

  base64_stream_decoder i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .in_kind_i       (in_kind),
    .in_character_i  (in_character),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .out_data_byte_o (out_data_byte),
    .out_status_o    (out_status),
    .out_is_last_o   (out_is_last)
  );

  base64_decode_checker i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_kind_i       (in_kind),
    .in_character_i  (in_character),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_data_byte_i (out_data_byte),
    .out_status_i    (out_status),
    .out_is_last_i   (out_is_last),
    .fail_count_o    (fail_count),
    .pending_o       (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver back-pressure
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= !steady_run && ($urandom_range(99) < 14);
    end
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("base64_stream_decoder_tb NOT OK");
    $finish;
  end

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    if (v < 26) return 8'("A") + 8'(v);
    if (v < 52) return 8'("a") + 8'(v - 26);
    if (v < 62) return 8'("0") + 8'(v - 52);
    if (v == 62) return "+";
    return "/";
  endfunction

  // One input transaction, with random gaps ahead of it
  task automatic send_item(input logic kind, input logic [7:0] ch);
    while (!steady_run && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_character <= ch;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (kind || !(ch == Blanks[0] || ch == Blanks[1] || ch == Blanks[2] || ch == Blanks[3]))
      sent_items++;
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_item(1'b0, s[i]);
    send_item(1'b1, 8'($urandom_range(255)));
  endtask

  // Drain everything in flight before going on
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
  endtask

  // Mostly well-formed base64 with random content, some damaged
  task automatic send_random_string();
    logic [7:0] text[$];
    int quanta;
    int pads;
    int flaw;
    quanta = $urandom_range(0, 6);
    pads   = $urandom_range(0, 2);
    flaw   = ($urandom_range(99) < 25) ? $urandom_range(FlawNoise, FlawGarbage) : FlawNone;
    if (flaw == FlawTruncate) pads = 0;
    for (int i = 0; i < quanta * 4; i++)
      text.insert(text.size(), b64_char(6'($urandom_range(63))));
    if (quanta > 0) begin
      for (int i = 1; i <= pads; i++) text[text.size() - i] = "=";
    end
    case (flaw)
      FlawNoise:    text.insert($urandom_range(text.size()), 8'($urandom_range(255)));
      FlawAfterPad: begin
        text.insert(text.size(), "=");
        text.insert(text.size(), b64_char(6'($urandom_range(63))));
      end
      FlawTruncate: text.insert(text.size(), b64_char(6'($urandom_range(63))));
      FlawGarbage:  repeat ($urandom_range(1, 6)) text.insert(text.size(), 8'($urandom_range(255)));
      default: ;
    endcase
    foreach (text[i]) begin
      if ($urandom_range(99) < 5) send_item(1'b0, Blanks[$urandom_range(3)]);
      send_item(1'b0, text[i]);
    end
    send_item(1'b1, 8'($urandom_range(255)));
  endtask

  initial begin
    int string_idx;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_kind      = 1'b0;
    in_character = 8'h00;
    steady_run   = 1'b0;
    sent_items   = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: full quantum with all whitespace, alphabet extremes,
    // data after padding, bad character then padding, truncated quantum
    send_string("TWFu \t\r\n");
    send_string("A/");
    send_string("z+90aZ=Q");
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'h00);
    send_string("B=");
    send_string("Q");

    // Random strings
    string_idx = 0;
    while (sent_items < ItemTarget) begin
      steady_run = (string_idx >= 40 && string_idx < 70);
      if (string_idx == 20) drain();
      send_random_string();
      string_idx++;
    end
    steady_run = 1'b0;

    drain();
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("base64_stream_decoder_tb OK");
    end else begin
      $display("base64_stream_decoder_tb NOT OK");
    end
    $finish;
  end

endmodule
